FILE: sv/wmmt_pkg.sv
// shared types and constants of the windowed mean / min / max tracker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wmmt_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_WINDOW_LENGTH = 2'd0,
        CFG_REJECT_DELAY  = 2'd1,
        CFG_NORM_LOW      = 2'd2,
        CFG_NORM_HIGH     = 2'd3
    } t_cfg_idx;

    // destination of a divider run
    typedef enum logic [1:0] {
        DIV_MEAN  = 2'd0,
        DIV_MNORM = 2'd1,
        DIV_ENORM = 2'd2
    } t_div_sel;

    // operation codes of an input item
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // divider operand widths (scaled numerator magnitude, denominator) and step counter width
    localparam int DIV_NW = 49;
    localparam int DIV_DW = 33;
    localparam int DIV_CW = 6;

    // commands from controller to datapath
    typedef struct packed {
        logic     clr;
        logic     load;
        logic     decide;
        logic     scan_rd;
        logic     scan_commit;
        logic     entry_rd;
        logic     div_start;
        t_div_sel div_sel;
        logic     out_load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic scan_last;
        logic is_tick;
        logic stored;
        logic div_done;
    } t_sts;

endpackage

`default_nettype wire

FILE: sv/wmmt_div.sv
// unsigned restoring divider, one quotient bit per cycle
// uses wmmt_pkg for operand widths
`timescale 1ns / 1ps
`default_nettype none

module wmmt_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [wmmt_pkg::DIV_NW-1:0] i_num,
    input  wire logic [wmmt_pkg::DIV_DW-1:0] i_den,
    output logic                             o_done,
    output logic [wmmt_pkg::DIV_NW-1:0]      o_quot
);

    localparam int RW = wmmt_pkg::DIV_DW + 1;

    logic [wmmt_pkg::DIV_NW-1:0] r_num;
    logic [wmmt_pkg::DIV_DW-1:0] r_den;
    logic [RW-1:0]               r_rem;
    logic [wmmt_pkg::DIV_CW-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [RW-1:0] w_rem_sh;
    logic [RW:0]   w_diff;
    logic          w_qbit;

    // trial subtract of the shifted remainder
    always_comb begin
        w_rem_sh = {r_rem[RW-2:0], r_num[wmmt_pkg::DIV_NW-1]};
        w_diff   = {1'b0, w_rem_sh} - {2'b00, r_den};
        w_qbit   = !w_diff[RW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= wmmt_pkg::DIV_CW'(wmmt_pkg::DIV_NW);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                // quotient bits shift in where numerator bits leave
                r_rem <= w_qbit ? w_diff[RW-1:0] : w_rem_sh;
                r_num <= {r_num[wmmt_pkg::DIV_NW-2:0], w_qbit};
                r_cnt <= r_cnt - wmmt_pkg::DIV_CW'(1);
                if (r_cnt == wmmt_pkg::DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

`default_nettype wire

FILE: sv/wmmt_ctrl.sv
// controller state machine of the tracker
// uses wmmt_pkg command and status structs
`timescale 1ns / 1ps
`default_nettype none

module wmmt_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    input  wire wmmt_pkg::t_sts i_sts,
    output wmmt_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_SCAN_END,
        ST_WAIT_MEAN,
        ST_ENTRY,
        ST_START_MNORM,
        ST_WAIT_MNORM,
        ST_WAIT_ENORM,
        ST_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    wmmt_pkg::t_cmd w_cmd;

    // next state and commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        w_cmd.div_sel = wmmt_pkg::DIV_MEAN;
        case (r_state)
            ST_CLEAR: begin
                w_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                w_cmd.decide = 1'b1;
                n_state = i_sts.is_tick ? ST_ENTRY : ST_SCAN;
            end
            ST_SCAN: begin
                w_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) n_state = ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT: n_state = ST_SCAN_END;
            ST_SCAN_END: begin
                w_cmd.scan_commit = 1'b1;
                if (i_sts.stored) begin
                    w_cmd.div_start = 1'b1;
                    w_cmd.div_sel   = wmmt_pkg::DIV_MEAN;
                    n_state         = ST_WAIT_MEAN;
                end else begin
                    n_state = ST_ENTRY;
                end
            end
            ST_WAIT_MEAN: begin
                if (i_sts.div_done) n_state = ST_ENTRY;
            end
            ST_ENTRY: begin
                w_cmd.entry_rd = 1'b1;
                n_state = ST_START_MNORM;
            end
            ST_START_MNORM: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = wmmt_pkg::DIV_MNORM;
                n_state         = ST_WAIT_MNORM;
            end
            ST_WAIT_MNORM: begin
                if (i_sts.div_done) begin
                    w_cmd.div_start = 1'b1;
                    w_cmd.div_sel   = wmmt_pkg::DIV_ENORM;
                    n_state         = ST_WAIT_ENORM;
                end
            end
            ST_WAIT_ENORM: begin
                if (i_sts.div_done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cmd.out_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

    // an accepted item blocks the input until its result is loaded
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after transfer");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_cmd.out_load)
        else $error("output register overwritten");

    // divider completions only arrive while a division is awaited
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == ST_WAIT_MEAN || r_state == ST_WAIT_MNORM ||
                            r_state == ST_WAIT_ENORM))
        else $error("unexpected divider completion");

endmodule

`default_nettype wire

FILE: sv/wmmt_dpath.sv
// datapath of the tracker: configuration, sample ring, scan, divider and result registers
// uses wmmt_pkg and wmmt_div
`timescale 1ns / 1ps
`default_nettype none

module wmmt_dpath #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_operation,
    input  wire logic signed [31:0] i_sample_value,
    input  wire logic [5:0]         i_entry_index,
    input  wire wmmt_pkg::t_cmd     i_cmd,
    output wmmt_pkg::t_sts          o_sts,
    output logic                    o_accepted,
    output logic signed [31:0]      o_window_mean,
    output logic [30:0]             o_window_max,
    output logic signed [31:0]      o_window_min,
    output logic signed [31:0]      o_mean_normalised,
    output logic signed [31:0]      o_entry_normalised
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = AW + 1;
    localparam int SW = 32 + AW;
    localparam int NW = wmmt_pkg::DIV_NW;
    localparam int DW = wmmt_pkg::DIV_DW;

    // configuration
    logic [6:0]         r_wlen;
    logic [19:0]        r_delay;
    logic signed [31:0] r_low;
    logic signed [31:0] r_high;

    // current item
    logic               r_op;
    logic signed [31:0] r_sample;
    logic [5:0]         r_idx;
    logic [CW-1:0]      r_len;

    // tracker state
    logic signed [31:0] r_ring [MAX_WINDOW];
    logic [AW-1:0]      r_wpos;
    logic [20:0]        r_ticks;
    logic               r_awaiting;
    logic signed [31:0] r_mean, r_max, r_min;
    logic               r_stored;

    // scan and result working registers
    logic [CW-1:0]      r_addr;
    logic               r_acc_vld;
    logic signed [SW-1:0] r_sum;
    logic signed [31:0] r_smax, r_smin;
    logic signed [31:0] r_rd_data;
    logic signed [31:0] r_mnorm, r_enorm;
    wmmt_pkg::t_div_sel r_div_sel;
    logic               r_div_neg;

    // output registers
    logic               r_o_acc;
    logic signed [31:0] r_o_mean, r_o_min, r_o_mnorm, r_o_enorm;
    logic [30:0]        r_o_max;

    // effective window length
    logic [CW-1:0] w_len;
    always_comb begin
        if (r_wlen == 7'd0) w_len = CW'(1);
        else if (int'(r_wlen) > MAX_WINDOW) w_len = CW'(MAX_WINDOW);
        else w_len = CW'(r_wlen);
    end

    // store decision and write position
    logic          w_delay_nz, w_store;
    logic [20:0]   w_t_eff;
    logic [AW-1:0] w_pos, w_wpos_next;
    logic [CW-1:0] w_pos_inc;
    always_comb begin
        w_delay_nz  = (r_delay != 20'd0);
        w_t_eff     = (r_awaiting && w_delay_nz) ? 21'd0 : r_ticks;
        w_store     = (r_op == wmmt_pkg::OP_SAMPLE) &&
                      (!w_delay_nz || (w_t_eff > {1'b0, r_delay}));
        w_pos       = ({1'b0, r_wpos} < r_len) ? r_wpos : '0;
        w_pos_inc   = {1'b0, w_pos} + CW'(1);
        w_wpos_next = (w_pos_inc >= r_len) ? '0 : w_pos_inc[AW-1:0];
    end

    // ring write and read port selection
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic signed [31:0] w_wdata;
    always_comb begin
        w_we    = i_cmd.clr || (i_cmd.decide && w_store);
        w_waddr = i_cmd.clr ? r_addr[AW-1:0] : w_pos;
        w_wdata = i_cmd.clr ? 32'sd0 : r_sample;
        w_raddr = i_cmd.entry_rd ? AW'(r_idx) : r_addr[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_ring[w_waddr] <= w_wdata;
        if (i_cmd.scan_rd || i_cmd.entry_rd) r_rd_data <= r_ring[w_raddr];
    end

    // divider operands
    logic               w_sum_neg;
    logic [SW-1:0]      w_sum_mag;
    logic signed [32:0] w_nv, w_range;
    logic               w_nv_neg, w_range_ok, w_idx_ok;
    logic [32:0]        w_nv_mag;
    logic [NW-1:0]      w_num;
    logic [DW-1:0]      w_den;
    logic               w_neg;
    always_comb begin
        w_sum_neg  = r_sum[SW-1];
        w_sum_mag  = w_sum_neg ? SW'(-r_sum) : SW'(r_sum);
        w_nv       = (i_cmd.div_sel == wmmt_pkg::DIV_MNORM)
                     ? ({r_mean[31], r_mean} - {r_low[31], r_low})
                     : ({r_rd_data[31], r_rd_data} - {r_low[31], r_low});
        w_nv_neg   = w_nv[32];
        w_nv_mag   = w_nv_neg ? 33'(-w_nv) : 33'(w_nv);
        w_range    = {r_high[31], r_high} - {r_low[31], r_low};
        w_range_ok = !w_range[32] && (w_range != 33'sd0);
        w_idx_ok   = int'(r_idx) < int'(r_len);
        if (i_cmd.div_sel == wmmt_pkg::DIV_MEAN) begin
            w_num = NW'(w_sum_mag);
            w_den = DW'(r_len);
            w_neg = w_sum_neg;
        end else begin
            w_num = {w_nv_mag, 16'd0};
            w_den = DW'(w_range);
            w_neg = w_nv_neg;
        end
    end

    logic          w_div_done;
    logic [NW-1:0] w_quot;

    wmmt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // signed quotient, plain and saturated
    logic signed [31:0] w_q32, w_qsat;
    always_comb begin
        w_q32 = r_div_neg ? -w_quot[31:0] : w_quot[31:0];
        if (r_div_neg)
            w_qsat = (w_quot > NW'(33'h080000000)) ? 32'sh80000000 : -w_quot[31:0];
        else
            w_qsat = (w_quot > NW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : w_quot[31:0];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen  <= 7'd64;
            r_delay <= 20'd0;
            r_low   <= 32'sd0;
            r_high  <= 32'sd65536;
        end else if (i_cfg_we) begin
            case (wmmt_pkg::t_cfg_idx'(i_cfg_index))
                wmmt_pkg::CFG_WINDOW_LENGTH: r_wlen  <= i_cfg_data[6:0];
                wmmt_pkg::CFG_REJECT_DELAY:  r_delay <= i_cfg_data[19:0];
                wmmt_pkg::CFG_NORM_LOW:      r_low   <= i_cfg_data;
                wmmt_pkg::CFG_NORM_HIGH:     r_high  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item capture, decision, scan and results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos     <= '0;
            r_ticks    <= '0;
            r_awaiting <= 1'b1;
            r_mean     <= '0;
            r_max      <= '0;
            r_min      <= '0;
            r_stored   <= 1'b0;
            r_addr     <= '0;
            r_acc_vld  <= 1'b0;
        end else begin
            r_acc_vld <= i_cmd.scan_rd;
            if (i_cmd.clr) r_addr <= r_addr + CW'(1);
            if (i_cmd.load) begin
                r_op     <= i_operation;
                r_sample <= i_sample_value;
                r_idx    <= i_entry_index;
                r_len    <= w_len;
            end
            if (i_cmd.decide) begin
                r_addr <= '0;
                r_sum  <= '0;
                r_smax <= '0;
                r_smin <= '0;
                if (r_op == wmmt_pkg::OP_TICK) begin
                    r_stored <= 1'b0;
                    if (r_ticks != '1) r_ticks <= r_ticks + 21'd1;
                end else begin
                    r_awaiting <= 1'b0;
                    r_stored   <= w_store;
                    r_ticks    <= (w_store && w_delay_nz) ? 21'd0 : w_t_eff;
                    if (w_store) r_wpos <= w_wpos_next;
                end
            end
            if (i_cmd.scan_rd) r_addr <= r_addr + CW'(1);
            // accumulate the entry read in the previous cycle
            if (r_acc_vld) begin
                r_sum <= r_sum + SW'(r_rd_data);
                if (r_rd_data > r_smax) r_smax <= r_rd_data;
                if (r_rd_data < r_smin) r_smin <= r_rd_data;
            end
            if (i_cmd.scan_commit) begin
                r_max <= r_smax;
                r_min <= r_smin;
            end
            if (w_div_done) begin
                case (r_div_sel)
                    wmmt_pkg::DIV_MEAN:  r_mean  <= w_q32;
                    wmmt_pkg::DIV_MNORM: r_mnorm <= w_range_ok ? w_qsat : 32'sd0;
                    wmmt_pkg::DIV_ENORM: r_enorm <= (w_range_ok && w_idx_ok) ? w_qsat : 32'sd0;
                    default: ;
                endcase
            end
            if (i_cmd.div_start) begin
                r_div_sel <= i_cmd.div_sel;
                r_div_neg <= w_neg;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_acc   <= r_stored;
            r_o_mean  <= r_mean;
            r_o_max   <= r_max[30:0];
            r_o_min   <= r_min;
            r_o_mnorm <= r_mnorm;
            r_o_enorm <= r_enorm;
        end
    end

    always_comb begin
        o_sts.clr_last  = (r_addr == CW'(MAX_WINDOW - 1));
        o_sts.scan_last = (r_addr == r_len - CW'(1));
        o_sts.is_tick   = (r_op == wmmt_pkg::OP_TICK);
        o_sts.stored    = r_stored;
        o_sts.div_done  = w_div_done;
    end

    assign o_accepted         = r_o_acc;
    assign o_window_mean      = r_o_mean;
    assign o_window_max       = r_o_max;
    assign o_window_min       = r_o_min;
    assign o_mean_normalised  = r_o_mnorm;
    assign o_entry_normalised = r_o_enorm;

    // a tick never reports a store
    a_tick_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.decide && r_op == wmmt_pkg::OP_TICK) |=> !r_stored)
        else $error("tick reported as stored");

    // the scan never runs past the window
    a_scan_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_rd |-> (r_addr < r_len))
        else $error("scan beyond window");

    // the maximum is never negative and the minimum never positive
    a_max_min_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_commit |=> (!r_max[31] && (r_min[31] || r_min == 32'sd0)))
        else $error("max or min not clamped to zero");

endmodule

`default_nettype wire

FILE: sv/windowed_mean_min_max_tracker_top.sv
// Windowed mean / min / max tracker over a ring of MAX_WINDOW signed Q16.16 samples.
// After reset the ring is cleared one entry per cycle, all MAX_WINDOW entries, while the
// input stays stalled. One item is processed at a time. A sample runs the ring scan,
// then the mean division when the sample is stored, then an entry read, the two
// normalising divisions and the result load; a tick skips the scan and the mean
// division. Both use the shared one-bit-per-cycle divider (49 steps per division) and
// the single ring read port. Results sit in an output register, so the next item is
// taken while one waits.
`timescale 1ns / 1ps
`default_nettype none

module windowed_mean_min_max_tracker_top #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_operation,
    input  wire logic signed [31:0] i_sample_value,
    input  wire logic [5:0]         i_entry_index,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_accepted,
    output logic signed [31:0]      o_window_mean,
    output logic [30:0]             o_window_max,
    output logic signed [31:0]      o_window_min,
    output logic signed [31:0]      o_mean_normalised,
    output logic signed [31:0]      o_entry_normalised
);

    wmmt_pkg::t_cmd w_cmd;
    wmmt_pkg::t_sts w_sts;

    // sequencing
    wmmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // storage and arithmetic
    wmmt_dpath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_operation        (i_operation),
        .i_sample_value     (i_sample_value),
        .i_entry_index      (i_entry_index),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .o_accepted         (o_accepted),
        .o_window_mean      (o_window_mean),
        .o_window_max       (o_window_max),
        .o_window_min       (o_window_min),
        .o_mean_normalised  (o_mean_normalised),
        .o_entry_normalised (o_entry_normalised)
    );

endmodule

`default_nettype wire
